// ----- src/smce_pkg.sv -----
package smce_pkg;

    // Field widths of one object and of the stream words.
    localparam int OBJ_W      = 3;
    localparam int POS_W      = 11;
    localparam int SIZE_W     = 8;
    localparam int DIR_W      = 4;
    localparam int TYPE_W     = 4;
    localparam int LIM_W      = 10;
    localparam int CMD_W      = 2;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 56;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam int NUM_OBJECTS_DEF = 8;

    // Bit positions of the two flags in the result word.
    localparam int OUT_COLLIDED_BIT = 0;
    localparam int OUT_NOTE_BIT     = 1;

    localparam logic [LIM_W-1:0] LEFT_RST   = 10'd10;
    localparam logic [LIM_W-1:0] TOP_RST    = 10'd10;
    localparam logic [LIM_W-1:0] RIGHT_RST  = 10'd310;
    localparam logic [LIM_W-1:0] BOTTOM_RST = 10'd230;

    localparam logic signed [DIR_W-1:0] DIR_POS = 4'sd1;
    localparam logic signed [DIR_W-1:0] DIR_NEG = -4'sd1;

    localparam logic [TYPE_W-1:0] TYPE_FIRST = 4'd1;
    localparam logic [TYPE_W-1:0] TYPE_LAST  = 4'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD,
        CMD_MOVE,
        CMD_COLLIDE,
        CMD_SHAPE
    } t_cmd;

    typedef enum logic [1:0] {
        REG_LEFT,
        REG_TOP,
        REG_RIGHT,
        REG_BOTTOM
    } t_reg;

    typedef struct packed {
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic        [SIZE_W-1:0] w;
        logic        [SIZE_W-1:0] h;
        logic signed [DIR_W-1:0]  dx;
        logic signed [DIR_W-1:0]  dy;
        logic        [TYPE_W-1:0] typ;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ----- src/sprite_motion_collision_engine_top.sv -----
// Channel   | Direction | Handshake                      | Contents
// ----------+-----------+--------------------------------+------------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready  | one command word (tuser = command)
// m_axis    | out       | m_axis_tvalid / m_axis_tready  | one result word per command
// apb       | in        | psel, penable, pwrite, pready  | screen limits, four registers
//
// The input takes one word at a time and stays closed while the command reads the
// object table, executes and, for a collide that hits two distinct objects, writes
// object b back; a collide also reads object b. The result word is registered in
// execution; the spacing is set by the one read and one write port of the object
// table RAM, which sees one object per cycle in each direction.
// Reset is synchronous and active low; it clears the control state and the limits.
// A stalled result is held in the output register while the next word is accepted;
// that word then waits in execution until the output register frees up.
module sprite_motion_collision_engine_top
    import smce_pkg::*;
#(
    parameter int NUM_OBJECTS = NUM_OBJECTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata, lowest bit first: obj_a, obj_b, load_x, load_y, load_width,
    // load_height, load_dx, load_dy, load_type.
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: cmd.
    input  logic [CMD_W-1:0]      s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata, lowest bit first: collided, note, pos_x, pos_y, dir_x, dir_y,
    // size_w, size_h, shape_type, then four zero bits.
    output logic [OUT_DATA_W-1:0] m_axis_tdata,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = $clog2(NUM_OBJECTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDA,
        S_RDB,
        S_EXEC,
        S_WRB
    } t_state;

    // Object indexes wrap around the table size. The raw index is below eight,
    // so three conditional subtractions reduce it for any table of two or more.
    function automatic logic [AW-1:0] obj_index(input logic [OBJ_W-1:0] v);
        logic [OBJ_W-1:0] r;
        r = v;
        for (int k = 0; k < 3; k++) begin
            if (int'(r) >= NUM_OBJECTS) begin
                r = r - OBJ_W'(NUM_OBJECTS);
            end
        end
        return AW'(r);
    endfunction

    t_state                  r_state;
    t_cmd                    r_cmd;
    logic [AW-1:0]           r_ia;
    logic [AW-1:0]           r_ib;
    t_entry                  r_ld;
    t_entry                  r_ent_a;
    t_entry                  r_ent_b;
    t_entry                  r_new_b;
    logic                    r_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data;
    logic [LIM_W-1:0]        r_left;
    logic [LIM_W-1:0]        r_top;
    logic [LIM_W-1:0]        r_right;
    logic [LIM_W-1:0]        r_bottom;

    logic                    s_accept;
    logic                    slot_free;
    logic                    cfg_write;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [AW-1:0]           ram_raddr;
    t_entry                  ram_wdata;
    t_entry                  ram_rdata;

    t_entry                  n_ent_a;
    t_entry                  n_ent_b;
    logic                    n_collided;
    logic                    n_note;
    logic                    n_write_b;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !r_out_valid || m_axis_tready;
    assign cfg_write     = psel && penable && pwrite && pready;

    assign pready        = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        prdata = '0;
        unique case (t_reg'(paddr[3:2]))
            REG_LEFT:   prdata = CFG_DATA_W'(r_left);
            REG_TOP:    prdata = CFG_DATA_W'(r_top);
            REG_RIGHT:  prdata = CFG_DATA_W'(r_right);
            REG_BOTTOM: prdata = CFG_DATA_W'(r_bottom);
            default:    prdata = '0;
        endcase
    end

    // The table is read at object a on acceptance and at object b in the next
    // cycle; object a is written back when the result is produced, object b
    // in the following cycle. One command is in flight at a time, so no read
    // can overtake a pending write.
    assign ram_raddr = (r_state == S_IDLE) ? obj_index(s_axis_tdata[2:0]) : r_ib;
    assign ram_we    = ((r_state == S_EXEC) && slot_free) || (r_state == S_WRB);
    assign ram_waddr = (r_state == S_WRB) ? r_ib : r_ia;
    assign ram_wdata = (r_state == S_WRB) ? r_new_b : n_ent_a;

    smce_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_OBJECTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Command execution. All edge and box comparisons are done in 13-bit signed
    // arithmetic so that a limit minus a size may go negative without wrapping.
    always_comb begin
        logic signed [12:0] ax, ay, aw, ah;
        logic signed [12:0] bx, by, bw, bh;
        logic signed [12:0] lim_l, lim_t, lim_r, lim_b;
        logic signed [DIR_W-1:0] dx, dy;
        logic touch, a_below, b_below, a_right, b_right;
        logic flip_h, flip_v;

        ax = 13'(r_ent_a.x);
        ay = 13'(r_ent_a.y);
        aw = 13'(r_ent_a.w);
        ah = 13'(r_ent_a.h);
        bx = 13'(r_ent_b.x);
        by = 13'(r_ent_b.y);
        bw = 13'(r_ent_b.w);
        bh = 13'(r_ent_b.h);
        lim_l = 13'(r_left);
        lim_t = 13'(r_top);
        lim_r = 13'(r_right);
        lim_b = 13'(r_bottom);
        dx = r_ent_a.dx;
        dy = r_ent_a.dy;

        touch   = (ax + aw >= bx) && (ax <= bx + bw) && (ay + ah >= by) && (ay <= by + bh);
        a_below = (ay == by + bh);
        b_below = (by == ay + ah);
        a_right = (ax == bx + bw);
        b_right = (bx == ax + aw);
        flip_v  = a_below || b_below;
        flip_h  = (a_right || b_right) && !flip_v;
        if (flip_v && (a_right || b_right)) begin
            flip_h = 1'b1;
        end

        n_ent_a    = r_ent_a;
        n_ent_b    = r_ent_b;
        n_collided = 1'b0;
        n_note     = 1'b0;
        n_write_b  = 1'b0;

        unique case (r_cmd)
            CMD_LOAD: begin
                n_ent_a = r_ld;
            end
            CMD_MOVE: begin
                if (ax < lim_l) begin
                    dx     = DIR_POS;
                    n_note = 1'b1;
                end else if (ax > lim_r - aw) begin
                    dx     = DIR_NEG;
                    n_note = 1'b1;
                end
                if (ay < lim_t) begin
                    dy     = DIR_POS;
                    n_note = 1'b1;
                end else if (ay > lim_b - ah) begin
                    dy     = DIR_NEG;
                    n_note = 1'b1;
                end
                n_ent_a.dx = dx;
                n_ent_a.dy = dy;
                n_ent_a.x  = r_ent_a.x + POS_W'(dx);
                n_ent_a.y  = r_ent_a.y + POS_W'(dy);
            end
            CMD_COLLIDE: begin
                // An object colliding with itself always touches, and any
                // reversal lands on it twice, so its steps stay as they are.
                if (r_ia == r_ib) begin
                    n_collided = 1'b1;
                    n_note     = 1'b1;
                end else if (touch) begin
                    n_collided = 1'b1;
                    n_note     = 1'b1;
                    n_write_b  = 1'b1;
                    if (flip_h) begin
                        n_ent_a.dx = DIR_W'(-r_ent_a.dx);
                        n_ent_b.dx = DIR_W'(-r_ent_b.dx);
                    end
                    if (flip_v) begin
                        n_ent_a.dy = DIR_W'(-r_ent_a.dy);
                        n_ent_b.dy = DIR_W'(-r_ent_b.dy);
                    end
                end
            end
            CMD_SHAPE: begin
                case (r_ent_a.typ) inside
                    4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd10: begin
                        n_ent_a.h = r_ent_a.w;
                    end
                    4'd4: begin
                        n_ent_a.h = r_ent_a.h;
                    end
                    4'd7, 4'd8: begin
                        n_ent_a.w = r_ent_a.w >> 1;
                        n_ent_a.h = r_ent_a.w;
                    end
                    4'd9: begin
                        n_ent_a.h = r_ent_a.w >> 1;
                    end
                    default: begin
                        n_ent_a.h = r_ent_a.h;
                    end
                endcase
                if (r_ent_a.typ == TYPE_LAST) begin
                    n_ent_a.typ = TYPE_FIRST;
                end else if ((r_ent_a.typ >= TYPE_FIRST) && (r_ent_a.typ < TYPE_LAST)) begin
                    n_ent_a.typ = r_ent_a.typ + TYPE_W'(1);
                end
            end
            default: begin
                n_ent_a = r_ent_a;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_left      <= LEFT_RST;
            r_top       <= TOP_RST;
            r_right     <= RIGHT_RST;
            r_bottom    <= BOTTOM_RST;
        end else begin
            if (cfg_write) begin
                unique case (t_reg'(paddr[3:2]))
                    REG_LEFT:   r_left   <= pwdata[LIM_W-1:0];
                    REG_TOP:    r_top    <= pwdata[LIM_W-1:0];
                    REG_RIGHT:  r_right  <= pwdata[LIM_W-1:0];
                    REG_BOTTOM: r_bottom <= pwdata[LIM_W-1:0];
                    default:    r_left   <= r_left;
                endcase
            end

            // A new result fills the output register in the same cycle that a
            // waiting one leaves it.
            if ((r_state == S_EXEC) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_cmd      <= t_cmd'(s_axis_tuser);
                        r_ia       <= obj_index(s_axis_tdata[2:0]);
                        r_ib       <= obj_index(s_axis_tdata[5:3]);
                        r_ld.x     <= s_axis_tdata[16:6];
                        r_ld.y     <= s_axis_tdata[27:17];
                        r_ld.w     <= s_axis_tdata[35:28];
                        r_ld.h     <= s_axis_tdata[43:36];
                        r_ld.dx    <= s_axis_tdata[47:44];
                        r_ld.dy    <= s_axis_tdata[51:48];
                        r_ld.typ   <= s_axis_tdata[55:52];
                        r_state    <= S_RDA;
                    end
                end
                S_RDA: begin
                    r_ent_a <= ram_rdata;
                    r_state <= (r_cmd == CMD_COLLIDE) ? S_RDB : S_EXEC;
                end
                S_RDB: begin
                    r_ent_b <= ram_rdata;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (slot_free) begin
                        r_out_data  <= {4'b0000, n_ent_a.typ, n_ent_a.h, n_ent_a.w,
                                        n_ent_a.dy, n_ent_a.dx, n_ent_a.y, n_ent_a.x,
                                        n_note, n_collided};
                        r_new_b     <= n_ent_b;
                        r_state     <= n_write_b ? S_WRB : S_IDLE;
                    end
                end
                S_WRB: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/smce_ram.sv -----
module smce_ram #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/smce_checker.sv -----
module smce_checker
    import smce_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic       s_acc;
    logic       m_acc;
    logic [1:0] r_pend;

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;

    // Words accepted whose results have not yet been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else if (s_acc && !m_acc) begin
            r_pend <= r_pend + 2'd1;
        end else if (m_acc && !s_acc) begin
            r_pend <= r_pend - 2'd1;
        end
    end

    // One command is worked on at a time: the input closes after each word.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !s_axis_tready)
        else $error("input accepted on two consecutive cycles");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    a_collide_notes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_COLLIDED_BIT] |-> m_axis_tdata[OUT_NOTE_BIT])
        else $error("collision reported without a note");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pend != 2'd0)
        else $error("result shown with no command outstanding");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("more than two commands outstanding");

endmodule

bind sprite_motion_collision_engine_top smce_checker u_smce_checker (.*);

// ----- bench/smce_bench_pkg.sv -----
package smce_bench_pkg;
    import smce_pkg::*;

    // One command word as it travels on s_axis_tdata, the last field declared in the lowest bits.
    typedef struct packed {
        logic        [TYPE_W-1:0] typ;
        logic signed [DIR_W-1:0]  dy;
        logic signed [DIR_W-1:0]  dx;
        logic        [SIZE_W-1:0] h;
        logic        [SIZE_W-1:0] w;
        logic signed [POS_W-1:0]  y;
        logic signed [POS_W-1:0]  x;
        logic        [OBJ_W-1:0]  b;
        logic        [OBJ_W-1:0]  a;
    } t_cmd_word;

    // One result word as it travels on m_axis_tdata.
    typedef struct packed {
        logic        [3:0]        pad;
        logic        [TYPE_W-1:0] typ;
        logic        [SIZE_W-1:0] h;
        logic        [SIZE_W-1:0] w;
        logic signed [DIR_W-1:0]  dy;
        logic signed [DIR_W-1:0]  dx;
        logic signed [POS_W-1:0]  y;
        logic signed [POS_W-1:0]  x;
        logic                     note;
        logic                     collided;
    } t_report;

    // Mirrors the object table and the screen limits, and keeps the result words
    // that the block still owes in the order of the commands.
    class t_sprite_tracker;
        t_entry           objs[NUM_OBJECTS_DEF];
        logic [LIM_W-1:0] limits[4];
        t_report          expected_reports[$];
        int               errors;

        function new();
            limits[REG_LEFT]   = LEFT_RST;
            limits[REG_TOP]    = TOP_RST;
            limits[REG_RIGHT]  = RIGHT_RST;
            limits[REG_BOTTOM] = BOTTOM_RST;
            errors = 0;
        endfunction

        function void set_limit(t_reg r, logic [LIM_W-1:0] v);
            limits[r] = v;
        endfunction

        // Negation stays in four bits, so a step of -8 reverses to itself.
        function void reverse_x(int i);
            objs[i].dx = -objs[i].dx;
        endfunction

        function void reverse_y(int i);
            objs[i].dy = -objs[i].dy;
        endfunction

        function void note_command(t_cmd cmd, t_cmd_word c);
            int      ia, ib;
            int      ax, ay, aw, ah, bx, by, bw, bh;
            bit      a_below, b_below, a_right, b_right, known;
            t_report r;
            ia = int'(c.a);
            ib = int'(c.b);
            r = '0;
            case (cmd)
                CMD_LOAD: begin
                    objs[ia] = '{x: c.x, y: c.y, w: c.w, h: c.h, dx: c.dx, dy: c.dy,
                                 typ: c.typ};
                end
                CMD_MOVE: begin
                    ax = int'(objs[ia].x);
                    ay = int'(objs[ia].y);
                    aw = int'(objs[ia].w);
                    ah = int'(objs[ia].h);
                    // The limit minus the size may go negative; compare as integers.
                    if (ax < int'(limits[REG_LEFT])) begin
                        objs[ia].dx = DIR_POS;
                        r.note = 1'b1;
                    end else if (ax > int'(limits[REG_RIGHT]) - aw) begin
                        objs[ia].dx = DIR_NEG;
                        r.note = 1'b1;
                    end
                    if (ay < int'(limits[REG_TOP])) begin
                        objs[ia].dy = DIR_POS;
                        r.note = 1'b1;
                    end else if (ay > int'(limits[REG_BOTTOM]) - ah) begin
                        objs[ia].dy = DIR_NEG;
                        r.note = 1'b1;
                    end
                    objs[ia].x = POS_W'(ax + int'(objs[ia].dx));
                    objs[ia].y = POS_W'(ay + int'(objs[ia].dy));
                end
                CMD_COLLIDE: begin
                    ax = int'(objs[ia].x);
                    ay = int'(objs[ia].y);
                    aw = int'(objs[ia].w);
                    ah = int'(objs[ia].h);
                    bx = int'(objs[ib].x);
                    by = int'(objs[ib].y);
                    bw = int'(objs[ib].w);
                    bh = int'(objs[ib].h);
                    if (ax + aw >= bx && ax <= bx + bw && ay + ah >= by && ay <= by + bh) begin
                        r.collided = 1'b1;
                        r.note = 1'b1;
                        a_below = (ay == by + bh);
                        b_below = (by == ay + ah);
                        a_right = (ax == bx + bw);
                        b_right = (bx == ax + aw);
                        // With a equal to b every reversal lands twice and cancels.
                        if ((a_right && a_below) || (b_right && b_below) ||
                            (a_below && b_right) || (b_below && a_right)) begin
                            reverse_x(ia);
                            reverse_x(ib);
                            reverse_y(ia);
                            reverse_y(ib);
                        end else if (a_below || b_below) begin
                            reverse_y(ia);
                            reverse_y(ib);
                        end else if (a_right || b_right) begin
                            reverse_x(ia);
                            reverse_x(ib);
                        end
                    end
                end
                CMD_SHAPE: begin
                    aw = int'(objs[ia].w);
                    known = 1'b1;
                    // The case is on the current type; the sizes are those of the next one.
                    case (objs[ia].typ)
                        1, 2, 3, 5, 6, 10: objs[ia].h = SIZE_W'(aw);
                        4: ;
                        7, 8: begin
                            objs[ia].w = SIZE_W'(aw / 2);
                            objs[ia].h = SIZE_W'(aw);
                        end
                        9: objs[ia].h = SIZE_W'(aw / 2);
                        default: known = 1'b0;
                    endcase
                    if (known) begin
                        objs[ia].typ = (objs[ia].typ == TYPE_LAST) ? TYPE_FIRST
                                                                   : TYPE_W'(objs[ia].typ + 1);
                    end
                end
            endcase
            r.x   = objs[ia].x;
            r.y   = objs[ia].y;
            r.dx  = objs[ia].dx;
            r.dy  = objs[ia].dy;
            r.w   = objs[ia].w;
            r.h   = objs[ia].h;
            r.typ = objs[ia].typ;
            expected_reports.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(t_report got);
            t_report want;
            if (expected_reports.size() == 0) begin
                $error("result word arrived with no command outstanding");
                errors++;
            end else begin
                want = expected_reports.pop_front();
                compare_field("collided", int'(want.collided), int'(got.collided));
                compare_field("note", int'(want.note), int'(got.note));
                compare_field("pos_x", int'(want.x), int'(got.x));
                compare_field("pos_y", int'(want.y), int'(got.y));
                compare_field("dir_x", int'(want.dx), int'(got.dx));
                compare_field("dir_y", int'(want.dy), int'(got.dy));
                compare_field("size_w", int'(want.w), int'(got.w));
                compare_field("size_h", int'(want.h), int'(got.h));
                compare_field("shape_type", int'(want.typ), int'(got.typ));
            end
        endfunction
    endclass

endpackage

// ----- bench/sprite_motion_collision_engine_top_test.sv -----
module sprite_motion_collision_engine_top_test
    import smce_pkg::*, smce_bench_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // A stretch of this many cycles with no handshake anywhere means the block hung.
    localparam int IDLE_LIMIT      = 1000;
    // Length of the one long receiver stall that backs the pipe up into the input.
    localparam int LONG_HOLD       = 80;
    localparam int ITEMS_PER_PHASE = 320;
    localparam int NUM_PHASES      = 6;
    // Extra wait after the last result so that the write-back of a collide that hits two objects is done.
    localparam int DRAIN_CYCLES    = 10;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [CMD_W-1:0]      s_axis_tuser  = '0;

    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    t_sprite_tracker tracker = new();

    // Sender burst bookkeeping: words left in the current back-to-back burst.
    int burst_left   = 0;
    // Set by the stimulus to ask the receiver for its long stall.
    bit hold_request = 1'b0;
    // The last load placed against another object; a later collide favors this pair
    // so that exact edge and corner touches are actually tested.
    int last_a = -1;
    int last_b = -1;

    // Receiver state.
    int rx_mode   = 0;
    int rx_left   = 0;
    int rx_count  = 0;
    int hold_left = 0;

    sprite_motion_collision_engine_top #(
        .NUM_OBJECTS(NUM_OBJECTS_DEF)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #2 i_clk = ~i_clk;

    // Result side. Each accepted result word is checked against the oldest expected
    // one. Readiness follows a pattern that is picked anew at random when its stretch runs out: always
    // ready, mostly ready, a fixed one-in-three stall, or mostly stalled. A request
    // from the stimulus replaces the pattern by one long stall, counted here.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_report(m_axis_tdata);
        end
        rx_count++;
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 99) < 70);
                2: m_axis_tready <= (rx_count % 3 != 0);
                default: m_axis_tready <= ($urandom_range(0, 99) < 25);
            endcase
        end
    end

    // Watchdog: any handshake on either stream or on the register port counts as
    // progress. A run that stops making progress ends as a failure.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready) || (psel && penable)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("sprite_motion_collision_engine_top_test NOT OK");
        $finish;
    end

    function automatic t_cmd_word noise_word();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return t_cmd_word'(r[IN_DATA_W-1:0]);
    endfunction

    // Offers one command word and returns at the edge that accepts it. Between
    // bursts the valid drops for a random gap; inside a burst it stays high, so the
    // next word goes out in the same step without lowering valid first.
    task automatic send_cmd(t_cmd cmd, t_cmd_word word);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.note_command(cmd, word);
    endtask

    // The unused fields carry random bits, which the block must ignore.
    task automatic load_obj(int idx, int x, int y, int w, int h, int dx, int dy, int typ);
        t_cmd_word word;
        word = noise_word();
        word.a   = OBJ_W'(idx);
        word.x   = POS_W'(x);
        word.y   = POS_W'(y);
        word.w   = SIZE_W'(w);
        word.h   = SIZE_W'(h);
        word.dx  = DIR_W'(dx);
        word.dy  = DIR_W'(dy);
        word.typ = TYPE_W'(typ);
        send_cmd(CMD_LOAD, word);
    endtask

    task automatic run_cmd(t_cmd cmd, int a, int b);
        t_cmd_word word;
        word = noise_word();
        word.a = OBJ_W'(a);
        word.b = OBJ_W'(b);
        send_cmd(cmd, word);
    endtask

    // Lowers valid and waits until every result word has come back, plus the
    // block's latency, so that a register write never lands on a busy pipe.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (tracker.expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the bits above the limit width are random
    // and must be dropped by the block. The bus then returns to idle.
    task automatic write_limit(t_reg r, logic [LIM_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(r) << 2;
        pwdata  <= {22'($urandom()), v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.set_limit(r, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_limits(logic [LIM_W-1:0] l, logic [LIM_W-1:0] t,
                                  logic [LIM_W-1:0] rt, logic [LIM_W-1:0] b);
        wait_idle();
        write_limit(REG_LEFT, l);
        write_limit(REG_TOP, t);
        write_limit(REG_RIGHT, rt);
        write_limit(REG_BOTTOM, b);
    endtask

    // Picks a coordinate for a new box of extent own against a peer at pos with
    // extent size: flush on the far side, flush on the near side, or overlapping.
    function automatic int place_next_to(int pos, int size, int own);
        case ($urandom_range(0, 2))
            0: return pos + size;
            1: return pos - own;
            default: return pos + int'($urandom_range(0, size));
        endcase
    endfunction

    // Random traffic. Every entry was loaded by the directed part, so any index is
    // safe to read. Loads are a mix of raw random words, boxes in a band around the
    // screen, and boxes set flush against another object to provoke edge and corner
    // touches. Most types are the ten valid ones; the rest hit the unknown types.
    task automatic send_random_item();
        t_cmd_word word;
        t_entry    peer;
        int        pick, o, nw, nh;
        word = noise_word();
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            nw = $urandom_range(0, 48);
            nh = $urandom_range(0, 48);
            case ($urandom_range(0, 9))
                0, 1: ;
                2, 3, 4, 5: begin
                    word.x = POS_W'($urandom_range(0, 440) - 40);
                    word.y = POS_W'($urandom_range(0, 440) - 40);
                    word.w = SIZE_W'(nw);
                    word.h = SIZE_W'(nh);
                end
                default: begin
                    o = $urandom_range(0, NUM_OBJECTS_DEF - 1);
                    peer = tracker.objs[o];
                    word.w = SIZE_W'(nw);
                    word.h = SIZE_W'(nh);
                    word.x = POS_W'(place_next_to(int'(peer.x), int'(peer.w), nw));
                    word.y = POS_W'(place_next_to(int'(peer.y), int'(peer.h), nh));
                    last_a = int'(word.a);
                    last_b = o;
                end
            endcase
            if ($urandom_range(0, 9) != 0) begin
                word.typ = TYPE_W'($urandom_range(1, 10));
            end
            send_cmd(CMD_LOAD, word);
        end else if (pick < 60) begin
            send_cmd(CMD_MOVE, word);
        end else if (pick < 85) begin
            if (last_a >= 0 && $urandom_range(0, 1) == 1) begin
                word.a = OBJ_W'(last_a);
                word.b = OBJ_W'(last_b);
                last_a = -1;
            end else if ($urandom_range(0, 9) == 0) begin
                word.b = word.a;
            end
            send_cmd(CMD_COLLIDE, word);
        end else begin
            send_cmd(CMD_SHAPE, word);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset limits. Object 0 is the anchor box at
        // (100,100) of size 20x10; the others are placed against it.
        load_obj(0, 100, 100, 20, 10, 3, -2, 1);
        // Extreme fields: lowest x, highest y, largest size, unknown type.
        load_obj(1, -1024, 1023, 255, 255, -8, 7, 15);
        // The opposite extremes, with a zero size and type zero.
        load_obj(2, 1023, -1024, 0, 0, 7, -8, 0);
        // Touches the anchor's bottom-right corner exactly; its step of -8 must
        // survive reversal unchanged.
        load_obj(3, 120, 110, 5, 5, -8, 2, 10);
        run_cmd(CMD_COLLIDE, 0, 3);
        // Sits on the anchor's bottom edge: only the vertical steps reverse.
        load_obj(4, 110, 110, 4, 4, 2, 3, 8);
        run_cmd(CMD_COLLIDE, 4, 0);
        // Flush against the anchor's left side: only the horizontal steps reverse.
        load_obj(5, 80, 95, 20, 8, 1, 1, 7);
        run_cmd(CMD_COLLIDE, 5, 0);
        // Strictly inside the anchor: a hit, but no reversal.
        load_obj(6, 105, 102, 3, 3, -1, -1, 9);
        run_cmd(CMD_COLLIDE, 6, 0);
        // A clear miss.
        run_cmd(CMD_COLLIDE, 0, 2);
        // Self collisions, one of them on a zero-size box where a corner touch
        // reverses twice.
        run_cmd(CMD_COLLIDE, 0, 0);
        run_cmd(CMD_COLLIDE, 2, 2);
        // Past the left limit and below the bottom limit at once.
        run_cmd(CMD_MOVE, 1, 0);
        // Shape changes: two unknown types, the wrap from ten to one, and the
        // types that halve the width or the height.
        run_cmd(CMD_SHAPE, 1, 0);
        run_cmd(CMD_SHAPE, 2, 0);
        run_cmd(CMD_SHAPE, 3, 0);
        run_cmd(CMD_SHAPE, 4, 0);
        run_cmd(CMD_SHAPE, 5, 0);
        run_cmd(CMD_SHAPE, 6, 0);
        run_cmd(CMD_SHAPE, 0, 0);
        load_obj(7, 1023, 1023, 0, 0, 7, 7, 5);

        // With the screen opened to its full range, a move from the bottom-right corner
        // wraps both coordinates around.
        program_limits(10'd0, 10'd0, 10'd1023, 10'd1023);
        run_cmd(CMD_MOVE, 7, 0);

        // Random phases, each under its own screen limits.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                1: program_limits(10'd1023, 10'd1023, 10'd0, 10'd0);
                2: begin
                    program_limits(LIM_W'($urandom_range(0, 1023)),
                                   LIM_W'($urandom_range(0, 1023)),
                                   LIM_W'($urandom_range(0, 1023)),
                                   LIM_W'($urandom_range(0, 1023)));
                    // Long receiver stall while words keep coming back to back.
                    hold_request = 1'b1;
                    burst_left = 2 * LONG_HOLD;
                end
                3: program_limits(LIM_W'($urandom_range(0, 64)),
                                  LIM_W'($urandom_range(0, 64)),
                                  LIM_W'($urandom_range(200, 400)),
                                  LIM_W'($urandom_range(150, 300)));
                4: program_limits(LIM_W'($urandom_range(0, 1023)),
                                  LIM_W'($urandom_range(0, 1023)),
                                  LIM_W'($urandom_range(0, 1023)),
                                  LIM_W'($urandom_range(0, 1023)));
                5: program_limits(LEFT_RST, TOP_RST, RIGHT_RST, BOTTOM_RST);
                default: ;
            endcase
            repeat (ITEMS_PER_PHASE) send_random_item();
        end

        wait_idle();
        if (tracker.errors == 0) begin
            $display("sprite_motion_collision_engine_top_test OK");
        end else begin
            $display("sprite_motion_collision_engine_top_test NOT OK");
        end
        $finish;
    end

endmodule
